>>> rtl/mlpl_pkg.sv
// Shared types and constants for the memory layout parser and lookup block.
// No dependencies.
package mlpl_pkg;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  desc_char;
    logic        last_char;
    logic [31:0] lookup_address;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic [31:0] page_bytes;
    logic [2:0]  seg_kind;
    logic [3:0]  seg_slot;
    logic [4:0]  seg_total;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] last;
    logic [31:0] page;
    logic [2:0]  kind;
  } entry_t;

  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_ADDED   = 3'd1;
  localparam logic [2:0] ST_SKIPPED = 3'd2;
  localparam logic [2:0] ST_STOPPED = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_HIT     = 3'd5;
  localparam logic [2:0] ST_MISS    = 3'd6;

  localparam logic [3:0] PH_AT         = 4'd0;
  localparam logic [3:0] PH_NAME_FIRST = 4'd1;
  localparam logic [3:0] PH_NAME       = 4'd2;
  localparam logic [3:0] PH_ADDR_ZERO  = 4'd3;
  localparam logic [3:0] PH_ADDR_X     = 4'd4;
  localparam logic [3:0] PH_ADDR_FIRST = 4'd5;
  localparam logic [3:0] PH_ADDR_HEX   = 4'd6;
  localparam logic [3:0] PH_COUNT_FIRST = 4'd7;
  localparam logic [3:0] PH_COUNT      = 4'd8;
  localparam logic [3:0] PH_SIZE_FIRST = 4'd9;
  localparam logic [3:0] PH_SIZE       = 4'd10;
  localparam logic [3:0] PH_TYPE       = 4'd11;
  localparam logic [3:0] PH_STOP       = 4'd12;

endpackage

>>> rtl/mlpl_table.sv
// Segment table: one synchronous memory, one write port, one registered read port.
// Depends on mlpl_pkg.
module mlpl_table #(
  parameter int Depth = 16,
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  mlpl_pkg::entry_t  wr_data,
  input  logic [AW-1:0]     rd_addr,
  output mlpl_pkg::entry_t  rd_data
);

  mlpl_pkg::entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/memory_layout_parse_and_lookup_top.sv
// Top level: descriptor parser, segment close arithmetic and table scan.
// Depends on mlpl_pkg and mlpl_table.
// A descriptor beat that closes no segment is answered straight from the idle state; a closing
// beat passes through S_MUL1, S_MUL2 and S_OUT, for the multiply, the address update and the write.
// A lookup reads entries in order, through S_SCAN and S_SCAN_CHK for each, until a hit or the last
// filled entry; an empty table answers straight from the idle state. Input stalls until a result is taken.
// Reset is synchronous and active low; it empties the table and restarts the parser.
module memory_layout_parse_and_lookup_top #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mlpl_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mlpl_pkg::out_beat_t out_data
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SCAN, S_SCAN_CHK, S_OUT
  } state_t;

  state_t      state_r;
  logic [3:0]  phase_r;
  logic [31:0] base_r, cnt_r, size_r;
  logic [7:0]  unit_r, tchar_r;
  logic [1:0]  tlen_r;
  logic [CW-1:0] count_r;
  logic [2:0]  kind_r;
  logic [31:0] bytes_r, lkaddr_r;
  logic [CW-1:0] idx_r;
  mlpl_pkg::out_beat_t res_r;
  logic        out_valid_r;

  logic        wr_en;
  mlpl_pkg::entry_t wr_data, rd_data;
  logic [AW-1:0] rd_addr;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Parser combinational step.
  logic [7:0]  c;
  logic        is_dec, is_hex;
  logic [3:0]  hv;
  logic [3:0]  ph_n;
  logic [31:0] base_n, cnt_n, size_n;
  logic [7:0]  unit_n, tchar_n;
  logic [1:0]  tlen_n;
  logic [CW-1:0] count_n;
  logic        close;

  always_comb begin
    c      = in_data.desc_char;
    is_dec = (c >= 8'h30) && (c <= 8'h39);
    hv     = c[3:0];
    is_hex = is_dec;
    if (c >= 8'h61 && c <= 8'h66) begin
      is_hex = 1'b1;
      hv     = c[3:0] + 4'd9;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      is_hex = 1'b1;
      hv     = c[3:0] + 4'd9;
    end
    ph_n = phase_r; base_n = base_r; cnt_n = cnt_r; size_n = size_r;
    unit_n = unit_r; tchar_n = tchar_r; tlen_n = tlen_r; count_n = count_r;
    close = 1'b0;
    case (phase_r)
      mlpl_pkg::PH_AT: begin
        count_n = '0;
        base_n  = '0;
        ph_n = (c == 8'h40) ? mlpl_pkg::PH_NAME_FIRST : mlpl_pkg::PH_STOP;
      end
      mlpl_pkg::PH_NAME_FIRST: begin
        ph_n = (c == 8'h2f) ? mlpl_pkg::PH_STOP : mlpl_pkg::PH_NAME;
      end
      mlpl_pkg::PH_NAME: begin
        if (c == 8'h2f) ph_n = mlpl_pkg::PH_ADDR_ZERO;
      end
      mlpl_pkg::PH_ADDR_ZERO: begin
        ph_n = (c == 8'h30) ? mlpl_pkg::PH_ADDR_X : mlpl_pkg::PH_STOP;
      end
      mlpl_pkg::PH_ADDR_X: begin
        ph_n = (c == 8'h78) ? mlpl_pkg::PH_ADDR_FIRST : mlpl_pkg::PH_STOP;
      end
      mlpl_pkg::PH_ADDR_FIRST: begin
        if (is_hex) begin
          base_n = {28'd0, hv};
          ph_n = mlpl_pkg::PH_ADDR_HEX;
        end else begin
          ph_n = mlpl_pkg::PH_STOP;
        end
      end
      mlpl_pkg::PH_ADDR_HEX: begin
        if (is_hex) base_n = {base_r[27:0], hv};
        else ph_n = (c == 8'h2f) ? mlpl_pkg::PH_COUNT_FIRST : mlpl_pkg::PH_STOP;
      end
      mlpl_pkg::PH_COUNT_FIRST: begin
        if (is_dec) begin
          cnt_n = {28'd0, c[3:0]};
          ph_n = mlpl_pkg::PH_COUNT;
        end else begin
          ph_n = mlpl_pkg::PH_STOP;
        end
      end
      mlpl_pkg::PH_COUNT: begin
        if (is_dec) cnt_n = (cnt_r << 3) + (cnt_r << 1) + {28'd0, c[3:0]};
        else ph_n = (c == 8'h2a) ? mlpl_pkg::PH_SIZE_FIRST : mlpl_pkg::PH_STOP;
      end
      mlpl_pkg::PH_SIZE_FIRST: begin
        if (is_dec) begin
          size_n = {28'd0, c[3:0]};
          ph_n = mlpl_pkg::PH_SIZE;
        end else begin
          ph_n = mlpl_pkg::PH_STOP;
        end
      end
      mlpl_pkg::PH_SIZE: begin
        if (is_dec) begin
          size_n = (size_r << 3) + (size_r << 1) + {28'd0, c[3:0]};
        end else begin
          unit_n = c; tchar_n = '0; tlen_n = '0;
          ph_n = mlpl_pkg::PH_TYPE;
        end
      end
      mlpl_pkg::PH_TYPE: begin
        if (c == 8'h2c) begin
          close = 1'b1;
          ph_n = mlpl_pkg::PH_COUNT_FIRST;
        end else if (c == 8'h2f) begin
          close = 1'b1;
          ph_n = mlpl_pkg::PH_ADDR_ZERO;
        end else begin
          if (tlen_r == 2'd0) tchar_n = c;
          if (tlen_r < 2'd2) tlen_n = tlen_r + 2'd1;
        end
      end
      default: ph_n = mlpl_pkg::PH_STOP;
    endcase
    if (in_data.last_char && ph_n == mlpl_pkg::PH_TYPE) close = 1'b1;
  end

  // Close decision from the updated segment fields.
  logic        typed;
  logic [2:0]  kind_c;
  logic [31:0] scaled;
  always_comb begin
    typed  = (tlen_n == 2'd1);
    kind_c = tchar_n[2:0];
    scaled = size_n;
    if (unit_n == 8'h4b) begin
      scaled = {size_n[21:0], 10'd0};
    end else if (unit_n == 8'h4d) begin
      scaled = {size_n[11:0], 20'd0};
    end else if (unit_n >= 8'h61 && unit_n <= 8'h67 && !typed) begin
      typed  = 1'b1;
      kind_c = unit_n[2:0];
    end
    if (tlen_n[1]) typed = 1'b0;
  end

  // Result beat as it stands when an input beat is taken.
  mlpl_pkg::out_beat_t idle_res;
  always_comb begin
    idle_res = '0;
    if (in_data.opcode) begin
      idle_res.status    = mlpl_pkg::ST_MISS;
      idle_res.seg_total = 5'(count_r);
    end else begin
      if (close && !typed) idle_res.status = mlpl_pkg::ST_SKIPPED;
      else if (!close && ph_n == mlpl_pkg::PH_STOP) idle_res.status = mlpl_pkg::ST_STOPPED;
      else idle_res.status = mlpl_pkg::ST_PENDING;
      idle_res.seg_total = 5'(count_n);
    end
  end

  logic match;
  assign match = (rd_data.start <= lkaddr_r) && (rd_data.last >= lkaddr_r);

  assign rd_addr = idx_r[AW-1:0];
  assign wr_en   = (state_r == S_OUT) && (count_r < CW'(MAX_SEGMENTS));
  assign wr_data = {res_r.seg_start, res_r.seg_end, res_r.page_bytes, res_r.seg_kind};

  mlpl_table #(.Depth(MAX_SEGMENTS), .AW(AW)) u_table (
    .clk(clk), .wr_en(wr_en), .wr_addr(count_r[AW-1:0]), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= mlpl_pkg::PH_AT;
      base_r <= '0; cnt_r <= '0; size_r <= '0;
      unit_r <= '0; tchar_r <= '0; tlen_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            res_r <= idle_res;
            if (in_data.opcode) begin
              lkaddr_r <= in_data.lookup_address;
              idx_r <= '0;
              if (count_r == '0) begin
                out_valid_r <= 1'b1;
              end else begin
                state_r <= S_SCAN;
              end
            end else begin
              phase_r <= in_data.last_char ? mlpl_pkg::PH_AT : ph_n;
              base_r <= base_n; cnt_r <= cnt_n;
              size_r <= (close && typed) ? scaled : size_n;
              unit_r <= unit_n; tchar_r <= tchar_n; tlen_r <= tlen_n;
              count_r <= count_n;
              if (close && typed) begin
                kind_r <= kind_c;
                state_r <= S_MUL1;
              end else begin
                out_valid_r <= 1'b1;
              end
            end
          end
        end
        S_MUL1: begin
          bytes_r <= cnt_r * size_r;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          res_r.seg_start  <= base_r;
          res_r.seg_end    <= base_r + bytes_r - 32'd1;
          res_r.page_bytes <= size_r;
          res_r.seg_kind   <= kind_r;
          base_r <= base_r + bytes_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // The table write in this cycle takes the segment fields set in the previous one.
          if (count_r < CW'(MAX_SEGMENTS)) begin
            res_r.status <= mlpl_pkg::ST_ADDED;
            res_r.seg_slot <= 4'(count_r);
            res_r.seg_total <= 5'(count_r + CW'(1));
            count_r <= count_r + CW'(1);
          end else begin
            res_r.status <= mlpl_pkg::ST_FULL;
          end
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (match) begin
            res_r.status <= mlpl_pkg::ST_HIT;
            res_r.seg_start <= rd_data.start;
            res_r.seg_end <= rd_data.last;
            res_r.page_bytes <= rd_data.page;
            res_r.seg_kind <= rd_data.kind;
            res_r.seg_slot <= 4'(idx_r);
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (idx_r + CW'(1) >= count_r) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_SCAN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count exceeds table depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  a_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == mlpl_pkg::ST_HIT) |-> (5'(res_r.seg_slot) < res_r.seg_total))
    else $error("hit slot beyond table fill");

endmodule
